FILE: sv/prefix_code_table_decoder_core_assert.svh
// assertion macros shared by the decoder rtl
`ifndef PREFIX_CODE_TABLE_DECODER_CORE_ASSERT_SVH
`define PREFIX_CODE_TABLE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PCTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PCTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pctd_pkg.sv
// shared constants, types and helpers of the prefix code table decoder
`default_nettype none

package pctd_pkg;

  // table and code geometry
  localparam int TableDepth = 128;
  localparam int MaxCodeLen = 14;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CodeW      = 14;
  localparam int LenW       = 4;
  localparam int SymW       = 8;
  localparam int EntryW     = CodeW + LenW + SymW;

  // stream widths
  localparam int InDataW  = 40;
  localparam int InUserW  = 2;
  localparam int OutDataW = 8;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_BIT  = 2'd1,
    REQ_END  = 2'd2
  } req_type_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SYMRD,
    S_SYMWT,
    S_EMIT
  } state_t;

  // one table entry as held in the ram
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
    logic [SymW-1:0]  sym;
  } entry_t;

  // ones in the low len bits
  function automatic logic [CodeW-1:0] len_mask(input logic [LenW-1:0] len);
    logic [CodeW-1:0] m;
    m = '0;
    for (int i = 0; i < CodeW; i++) begin
      m[i] = (i < int'(len));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pctd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pctd_ram #(
  parameter int Width = 26,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/prefix_code_table_decoder_core.sv
// Prefix code table decoder: one shared entry compare unit scans the code table ram.
// Requests are accepted only while idle; a code bit scans the table, one entry compared per
// cycle, and a bit that breaks a pending match first emits it and then rescans for that bit.
// A flushing end reads and emits the pending symbol; a held output register adds stalls.
// Synchronous active-low reset clears control state and entry valid bits; ram is undefined.
`default_nettype none
`include "prefix_code_table_decoder_core_assert.svh"

module prefix_code_table_decoder_core import pctd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // entry_index[6:0], entry_code[20:7], entry_code_len[24:21],
  // entry_symbol[32:25], code_bit[33], zero pad[39:34]
  input  logic [InDataW-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [InUserW-1:0]  in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // symbol[7:0]
  output logic [OutDataW-1:0] out_tdata,
  // decode_error[0]
  output logic                out_tuser,
  output logic                out_tlast
);

  state_t state_r, state_nxt;

  // input field views
  req_type_t        in_req;
  logic [IdxW-1:0]  in_idx;
  logic [CodeW-1:0] in_code;
  logic [LenW-1:0]  in_len;
  logic [SymW-1:0]  in_sym;
  logic             in_bit;
  logic             in_acc;

  // decoder state
  logic [TableDepth-1:0] valid_r, valid_nxt;
  logic [CodeW-1:0]      buf_r, buf_nxt;
  logic [LenW-1:0]       len_r, len_nxt;
  logic [IdxW-1:0]       mt_idx_r, mt_idx_nxt;
  logic                  pend_r, pend_nxt;
  logic                  bit_r, bit_nxt;

  // search unit state
  logic [CodeW-1:0] key_buf_r, key_buf_nxt;
  logic [LenW-1:0]  key_len_r, key_len_nxt;
  logic [IdxW:0]    scan_r, scan_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IdxW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic             restart_r, restart_nxt;

  // result staging and output register
  logic [SymW-1:0] res_sym_r, res_sym_nxt;
  logic            res_err_r, res_err_nxt;
  logic            res_fin_r, res_fin_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SymW-1:0] out_sym_r, out_sym_nxt;
  logic            out_err_r, out_err_nxt;
  logic            out_fin_r, out_fin_nxt;

  // ram ports
  logic             ram_we;
  logic [IdxW-1:0]  ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [EntryW-1:0] ram_rdata_raw;

  // derived control
  logic [LenW-1:0]  nl;
  logic [CodeW-1:0] nb;
  logic             buf_full;
  logic             cmp_hit;
  logic             last_cmp;
  logic             srch_hit;
  logic             srch_miss;
  logic             out_free;
  logic             scan_more;

  assign in_req  = req_type_t'(in_tuser);
  assign in_idx  = in_tdata[6:0];
  assign in_code = in_tdata[20:7];
  assign in_len  = in_tdata[24:21];
  assign in_sym  = in_tdata[32:25];
  assign in_bit  = in_tdata[33];
  assign in_acc  = in_tvalid && in_tready;

  // buffer extended by the incoming bit
  assign nl       = len_r + LenW'(1);
  assign nb       = {buf_r[CodeW-2:0], in_bit} & len_mask(nl);
  assign buf_full = (len_r >= LenW'(MaxCodeLen));

  // shared entry compare unit
  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign cmp_hit   = cmp_vld_r && valid_r[cmp_idx_r] && (ram_rdata.len == key_len_r) &&
                     ((ram_rdata.code & len_mask(key_len_r)) == key_buf_r);
  assign last_cmp  = cmp_vld_r && (cmp_idx_r == IdxW'(TableDepth - 1));
  assign srch_hit  = (state_r == S_SEARCH) && cmp_hit;
  assign srch_miss = (state_r == S_SEARCH) && !cmp_hit && last_cmp;
  assign scan_more = (scan_r < (IdxW+1)'(TableDepth));
  assign out_free  = !out_valid_r || out_tready;

  // table ram
  assign ram_wdata = '{code: in_code, len: in_len, sym: in_sym};

  pctd_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req)
            REQ_BIT: begin
              if (!buf_full) begin
                state_nxt = S_SEARCH;
              end else if (pend_r) begin
                state_nxt = S_SYMRD;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            REQ_END: begin
              state_nxt = pend_r ? S_SYMRD : S_IDLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (srch_hit) begin
          state_nxt = S_IDLE;
        end else if (srch_miss) begin
          if (restart_r) begin
            state_nxt = S_IDLE;
          end else if (pend_r) begin
            state_nxt = S_SYMRD;
          end else if (key_len_r >= LenW'(MaxCodeLen)) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SYMRD: state_nxt = S_SYMWT;
      S_SYMWT: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = restart_r ? S_SEARCH : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = mt_idx_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ram_we    = in_tvalid && (in_req == REQ_LOAD);
      end
      S_SEARCH: ram_raddr = scan_r[IdxW-1:0];
      S_SYMRD,
      S_SYMWT,
      S_EMIT:   ram_raddr = mt_idx_r;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    valid_nxt     = valid_r;
    buf_nxt       = buf_r;
    len_nxt       = len_r;
    mt_idx_nxt    = mt_idx_r;
    pend_nxt      = pend_r;
    bit_nxt       = bit_r;
    key_buf_nxt   = key_buf_r;
    key_len_nxt   = key_len_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    restart_nxt   = restart_r;
    res_sym_nxt   = res_sym_r;
    res_err_nxt   = res_err_r;
    res_fin_nxt   = res_fin_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_err_nxt   = out_err_r;
    out_fin_nxt   = out_fin_r;

    case (state_r)
      // take a request
      S_IDLE: begin
        if (in_acc) begin
          case (in_req)
            REQ_LOAD: valid_nxt[in_idx] = 1'b1;
            REQ_BIT: begin
              bit_nxt     = in_bit;
              restart_nxt = 1'b0;
              if (!buf_full) begin
                key_buf_nxt = nb;
                key_len_nxt = nl;
                scan_nxt    = '0;
                cmp_vld_nxt = 1'b0;
              end else if (pend_r) begin
                res_fin_nxt = 1'b0;
                restart_nxt = 1'b1;
              end else begin
                buf_nxt     = '0;
                len_nxt     = '0;
                mt_idx_nxt  = '0;
                pend_nxt    = 1'b0;
                res_sym_nxt = '0;
                res_err_nxt = 1'b1;
                res_fin_nxt = 1'b0;
              end
            end
            REQ_END: begin
              restart_nxt = 1'b0;
              if (pend_r) begin
                res_fin_nxt = 1'b1;
              end else begin
                buf_nxt    = '0;
                len_nxt    = '0;
                mt_idx_nxt = '0;
                pend_nxt   = 1'b0;
              end
            end
            default: begin
              restart_nxt = restart_r;
            end
          endcase
        end
      end

      // one entry read issued and one compared per cycle
      S_SEARCH: begin
        if (scan_more) begin
          scan_nxt = scan_r + (IdxW+1)'(1);
        end
        cmp_vld_nxt = scan_more;
        cmp_idx_nxt = scan_r[IdxW-1:0];
        if (srch_hit) begin
          buf_nxt    = key_buf_r;
          len_nxt    = key_len_r;
          mt_idx_nxt = cmp_idx_r;
          pend_nxt   = 1'b1;
        end else if (srch_miss) begin
          if (restart_r) begin
            if (MaxCodeLen > 1) begin
              buf_nxt = key_buf_r;
              len_nxt = key_len_r;
            end
          end else if (pend_r) begin
            res_fin_nxt = 1'b0;
            restart_nxt = 1'b1;
          end else if (key_len_r >= LenW'(MaxCodeLen)) begin
            buf_nxt     = '0;
            len_nxt     = '0;
            mt_idx_nxt  = '0;
            res_sym_nxt = '0;
            res_err_nxt = 1'b1;
            res_fin_nxt = 1'b0;
          end else begin
            buf_nxt = key_buf_r;
            len_nxt = key_len_r;
          end
        end
      end

      // pending symbol arrives from the ram
      S_SYMWT: begin
        res_sym_nxt = ram_rdata.sym;
        res_err_nxt = 1'b0;
        buf_nxt     = '0;
        len_nxt     = '0;
        mt_idx_nxt  = '0;
        pend_nxt    = 1'b0;
      end

      // hand the result to the output register
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = res_sym_r;
          out_err_nxt   = res_err_r;
          out_fin_nxt   = res_fin_r;
          if (restart_r) begin
            key_buf_nxt = {{(CodeW-1){1'b0}}, bit_r};
            key_len_nxt = LenW'(1);
            scan_nxt    = '0;
            cmp_vld_nxt = 1'b0;
          end
        end
      end

      default: begin
        scan_nxt = scan_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      buf_r       <= '0;
      len_r       <= '0;
      mt_idx_r    <= '0;
      pend_r      <= 1'b0;
      cmp_vld_r   <= 1'b0;
      restart_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      buf_r       <= buf_nxt;
      len_r       <= len_nxt;
      mt_idx_r    <= mt_idx_nxt;
      pend_r      <= pend_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bit_r     <= bit_nxt;
    key_buf_r <= key_buf_nxt;
    key_len_r <= key_len_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_sym_r <= res_sym_nxt;
    res_err_r <= res_err_nxt;
    res_fin_r <= res_fin_nxt;
    out_sym_r <= out_sym_nxt;
    out_err_r <= out_err_nxt;
    out_fin_r <= out_fin_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_fin_r;

  // checks
  `PCTD_ASSERT_IMP(a_err_is_clean, out_tvalid && out_tuser, (out_tdata == '0) && !out_tlast, "error result carries a symbol or final mark")
  `PCTD_ASSERT_IMP(a_len_bound, 1'b1, len_r <= LenW'(MaxCodeLen), "bit buffer longer than the longest code")
  `PCTD_ASSERT_IMP(a_pend_len, pend_r, len_r != '0, "pending match with an empty buffer")
  `PCTD_ASSERT_NXT(a_hit_sets_pend, srch_hit, pend_r && (state_r == S_IDLE), "table hit not recorded")

endmodule

`default_nettype wire

FILE: bench/prefix_code_table_decoder_core_tb.sv
// self-checking stream testbench for the prefix code table decoder core
`timescale 1ns / 1ps

module prefix_code_table_decoder_core_tb;
  import pctd_pkg::*;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned ItemTarget   = 1850;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned HoldOffLen   = 4000;
  localparam int unsigned PrintLimit   = 40;
  localparam logic [1:0]  ReqReserved  = 2'd3;

  // layout of in_tdata, lowest field last
  typedef struct packed {
    logic [InDataW-35:0] pad;
    logic                code_bit;
    logic [SymW-1:0]     symbol;
    logic [LenW-1:0]     code_len;
    logic [CodeW-1:0]    code;
    logic [IdxW-1:0]     index;
  } request_word_t;

  // one decoded output
  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            err;
    logic            fin;
  } decoded_t;

  // mirror of the decoder state plus the queue of symbols it must still emit
  class decode_scoreboard;
    logic [CodeW-1:0] tab_code [TableDepth];
    logic [LenW-1:0]  tab_len  [TableDepth];
    logic [SymW-1:0]  tab_sym  [TableDepth];
    bit               tab_valid[TableDepth];
    logic [CodeW-1:0] shift_buf;
    int unsigned      shift_len;
    int unsigned      hit_idx;
    bit               hit_pending;
    decoded_t         expected_q[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      error_count;
    int unsigned      flush_count;

    function new();
      foreach (tab_valid[i]) begin
        tab_valid[i] = 1'b0;
        tab_code[i]  = '0;
        tab_len[i]   = '0;
        tab_sym[i]   = '0;
      end
      drop_buffer();
      mismatches  = 0;
      checked     = 0;
      error_count = 0;
      flush_count = 0;
    endfunction

    function void drop_buffer();
      shift_buf   = '0;
      shift_len   = 0;
      hit_idx     = 0;
      hit_pending = 1'b0;
    endfunction

    function logic [CodeW-1:0] low_bits(int unsigned n);
      logic [CodeW:0] m;
      m = ({{CodeW{1'b0}}, 1'b1} << n) - 1'b1;
      return m[CodeW-1:0];
    endfunction

    // lowest valid slot whose code equals the pattern at exactly n bits
    function int lowest_hit(logic [CodeW-1:0] pattern, int unsigned n);
      for (int i = 0; i < TableDepth; i++) begin
        if (tab_valid[i] && n != 0 && int'(tab_len[i]) == n &&
            (tab_code[i] & low_bits(n)) == pattern)
          return i;
      end
      return -1;
    endfunction

    function void expect_symbol(logic [SymW-1:0] s, bit err, bit fin);
      decoded_t d;
      d.sym = s;
      d.err = err;
      d.fin = fin;
      if (err) error_count++;
      if (fin) flush_count++;
      expected_q.push_back(d);
    endfunction

    // advance the mirror by one accepted request
    function void note_request(logic [InUserW-1:0] kind, logic [InDataW-1:0] data);
      request_word_t    w;
      logic [CodeW-1:0] nb;
      int unsigned      nl;
      int               m;
      bit               restart;
      w       = request_word_t'(data);
      restart = 1'b0;
      case (req_type_t'(kind))
        REQ_LOAD: begin
          tab_code[w.index]  = w.code;
          tab_len[w.index]   = w.code_len;
          tab_sym[w.index]   = w.symbol;
          tab_valid[w.index] = 1'b1;
        end
        REQ_END: begin
          if (hit_pending) expect_symbol(tab_sym[hit_idx], 1'b0, 1'b1);
          drop_buffer();
        end
        REQ_BIT: begin
          if (shift_len < MaxCodeLen) begin
            nl = shift_len + 1;
            nb = ((shift_buf << 1) | CodeW'(w.code_bit)) & low_bits(nl);
            m  = lowest_hit(nb, nl);
            if (m >= 0) begin
              shift_buf   = nb;
              shift_len   = nl;
              hit_idx     = m;
              hit_pending = 1'b1;
            end else if (hit_pending) begin
              restart = 1'b1;
            end else if (nl >= MaxCodeLen) begin
              drop_buffer();
              expect_symbol('0, 1'b1, 1'b0);
            end else begin
              shift_buf = nb;
              shift_len = nl;
            end
          end else if (hit_pending) begin
            restart = 1'b1;
          end else begin
            drop_buffer();
            expect_symbol('0, 1'b1, 1'b0);
          end
          // a bit that breaks a pending match emits it and starts a new buffer
          if (restart) begin
            expect_symbol(tab_sym[hit_idx], 1'b0, 1'b0);
            drop_buffer();
            shift_buf = CodeW'(w.code_bit);
            shift_len = 1;
            m = lowest_hit(CodeW'(w.code_bit), 1);
            if (m >= 0) begin
              hit_idx     = m;
              hit_pending = 1'b1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PrintLimit) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [SymW-1:0] s, logic err, logic fin);
      decoded_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result sym=%02h err=%0b fin=%0b", s, err, fin));
        return;
      end
      want = expected_q.pop_front();
      if (s !== want.sym)
        report($sformatf("symbol %02h, expected %02h", s, want.sym));
      if (err !== want.err)
        report($sformatf("decode_error %0b, expected %0b", err, want.err));
      if (fin !== want.fin)
        report($sformatf("final flag %0b, expected %0b", fin, want.fin));
    endtask
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [InUserW-1:0]  in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  decode_scoreboard sb;
  int unsigned      cycle_count = 0;
  int unsigned      sent_count  = 0;
  int unsigned      phase_count = 0;
  int unsigned      hold_count  = 0;
  bit               hold_off_req = 1'b0;
  bit               send_quiet   = 1'b0;
  bit               recv_quiet   = 1'b0;
  logic [IdxW-1:0]  live_slots[$];
  int unsigned      tree_code[$];
  int unsigned      tree_len[$];
  logic [IdxW-1:0]  tree_slot[$];

  prefix_code_table_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 125 MHz clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("prefix_code_table_decoder_core verification failed");
      $finish;
    end
  end

  // handshake monitor: note accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 80);
  endfunction

  // result side backpressure, with an occasional long hold-off
  initial begin
    int unsigned gap;
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
        hold_off_req = 1'b0;
        hold_count++;
      end else begin
        gap = pick_gap(recv_quiet);
        if (gap == 0) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // offer one request and hold it until accepted
  task automatic send_request(input logic [1:0] kind, input logic [IdxW-1:0] idx,
                              input logic [CodeW-1:0] code, input logic [LenW-1:0] len,
                              input logic [SymW-1:0] sym, input logic cbit);
    request_word_t w;
    int unsigned   gap;
    w.pad      = '0;
    w.code_bit = cbit;
    w.symbol   = sym;
    w.code_len = len;
    w.code     = code;
    w.index    = idx;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind != ReqReserved) sent_count++;
    gap = pick_gap(send_quiet);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [IdxW-1:0] idx, input logic [CodeW-1:0] code,
                            input logic [LenW-1:0] len, input logic [SymW-1:0] sym);
    if (len != 0 && len <= MaxCodeLen) live_slots.push_back(idx);
    send_request(REQ_LOAD, idx, code, len, sym, 1'($urandom_range(0, 1)));
  endtask

  // fields other than the bit are don't-care and get random values
  task automatic send_bit(input logic b);
    send_request(REQ_BIT, IdxW'($urandom), CodeW'($urandom), LenW'($urandom),
                 SymW'($urandom), b);
  endtask

  task automatic send_end();
    send_request(REQ_END, IdxW'($urandom), CodeW'($urandom), LenW'($urandom),
                 SymW'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // stop offering until every expected result is back and the core has settled
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // disable stale entries by rewriting them with a length that never matches
  task automatic retire_slots();
    logic [IdxW-1:0] old_slots[$];
    old_slots = live_slots;
    live_slots.delete();
    foreach (old_slots[i])
      load_entry(old_slots[i], CodeW'($urandom),
                 ($urandom_range(0, 1) != 0) ? LenW'(0) : LenW'(15), SymW'($urandom));
  endtask

  // random prefix-free code set, by splitting leaves of a binary tree
  task automatic build_code_set(input int unsigned leaves, input bit chain);
    int unsigned j;
    int unsigned c;
    int unsigned l;
    tree_code.delete();
    tree_len.delete();
    tree_code.push_back(0);
    tree_len.push_back(0);
    for (int k = 1; k < leaves; k++) begin
      if (chain) begin
        j = tree_code.size() - 1;
      end else begin
        do j = $urandom_range(0, tree_code.size() - 1);
        while (tree_len[j] >= MaxCodeLen);
      end
      c = tree_code[j];
      l = tree_len[j];
      tree_code[j] = c << 1;
      tree_len[j]  = l + 1;
      tree_code.push_back((c << 1) | 1);
      tree_len.push_back(l + 1);
    end
  endtask

  // load a fresh code set, stream encoded symbols through it, then usually close the stream
  task automatic coded_phase(input bit hold_off);
    bit          slot_taken[TableDepth];
    int unsigned leaves;
    int unsigned nsym;
    int unsigned k;
    int unsigned s;
    bit          chain;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    if ($urandom_range(0, 4) != 0) retire_slots();
    chain  = ($urandom_range(0, 4) == 0);
    leaves = chain ? MaxCodeLen + 1 : $urandom_range(2, 12);
    build_code_set(leaves, chain);
    tree_slot.delete();
    foreach (tree_code[i]) begin
      do s = $urandom_range(0, TableDepth - 1);
      while (slot_taken[s]);
      slot_taken[s] = 1'b1;
      tree_slot.push_back(IdxW'(s));
      // junk above the code length must be ignored
      load_entry(IdxW'(s), CodeW'(($urandom_range(0, 16383) << tree_len[i]) | tree_code[i]),
                 LenW'(tree_len[i]), SymW'($urandom));
    end
    // a second slot with the same code: the lower index wins
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, tree_code.size() - 1);
      do s = $urandom_range(0, TableDepth - 1);
      while (slot_taken[s]);
      slot_taken[s] = 1'b1;
      load_entry(IdxW'(s), CodeW'(tree_code[k]), LenW'(tree_len[k]), SymW'($urandom));
    end
    if (hold_off) begin
      send_quiet   = 1'b1;
      hold_off_req = 1'b1;
    end
    nsym = $urandom_range(8, 40);
    repeat (nsym) begin
      k = $urandom_range(0, tree_code.size() - 1);
      for (int b = int'(tree_len[k]) - 1; b >= 0; b--) send_bit(1'((tree_code[k] >> b) & 1));
      // rewrite a slot mid-stream with a new symbol
      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(0, tree_code.size() - 1);
        load_entry(tree_slot[k], CodeW'(tree_code[k]), LenW'(tree_len[k]), SymW'($urandom));
      end
    end
    if ($urandom_range(0, 19) < 17) send_end();
  endtask

  // unstructured requests: stray bits, random loads, ends and reserved kinds
  task automatic noise_phase();
    int unsigned cnt;
    int unsigned r;
    cnt = $urandom_range(30, 80);
    repeat (cnt) begin
      r = $urandom_range(0, 99);
      if (r < 65)
        send_bit(1'($urandom_range(0, 1)));
      else if (r < 80)
        load_entry(IdxW'($urandom_range(0, TableDepth - 1)), CodeW'($urandom_range(0, 16383)),
                   LenW'($urandom_range(0, 15)), SymW'($urandom_range(0, 255)));
      else if (r < 94)
        send_end();
      else
        send_request(ReqReserved, IdxW'($urandom), CodeW'($urandom), LenW'($urandom),
                     SymW'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // main sequence
  initial begin
    bit hold_phase;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty end, reserved kind, odd lengths, stray bits, shadowing,
    // reload while pending, flush, and a full 14-bit code broken at full length
    send_end();
    send_request(ReqReserved, 7'h7F, 14'h3FFF, 4'hF, 8'hFF, 1'b1);
    load_entry(7'd0, 14'h3FFE, 4'd1, 8'h00);
    load_entry(7'd1, 14'h0000, 4'd0, 8'hAA);
    load_entry(7'd2, 14'h0001, 4'd15, 8'h55);
    load_entry(7'd127, 14'h3FFF, 4'd14, 8'hFF);
    load_entry(7'd3, 14'h0002, 4'd2, 8'h81);
    load_entry(7'd5, 14'h0002, 4'd2, 8'h22);
    send_bit(1'b0);
    send_bit(1'b0);
    load_entry(7'd0, 14'h0000, 4'd1, 8'h7E);
    send_end();
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    repeat (MaxCodeLen) send_bit(1'b1);
    send_end();
    drain_results();

    // random phases
    while (sent_count < ItemTarget) begin
      phase_count++;
      hold_phase = (phase_count == 1 || phase_count == 9);
      send_quiet = ($urandom_range(0, 5) == 0);
      recv_quiet = ($urandom_range(0, 5) == 0);
      if (hold_phase || $urandom_range(0, 9) < 7)
        coded_phase(hold_phase);
      else
        noise_phase();
      if (phase_count % 4 == 0) drain_results();
    end
    drain_results();

    $display("covered %0d requests in %0d random phases, %0d long output hold-offs",
             sent_count, phase_count, hold_count);
    $display("checked %0d results: %0d decode errors, %0d end-of-stream flushes",
             sb.checked, sb.error_count, sb.flush_count);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("prefix_code_table_decoder_core verification clean");
    else
      $display("prefix_code_table_decoder_core verification failed");
    $finish;
  end

endmodule
